FILE: src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants, register codes and pipeline control type for the
// ray/sphere intersection core.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int DIR_W      = 18;
    localparam int DIR_FRAC   = 16;
    localparam int RADIUS_W   = 23;
    localparam int T_W        = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic miss;
    } ctl_t;

endpackage

FILE: src/rsi_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// rsi_isqrt_pipe
// Pipelined floor square root, one result bit per register stage, with a
// control word and a side payload carried alongside each radicand.
// ----------------------------------------------------------------------------
module rsi_isqrt_pipe #(
    parameter int ROOT_W = rsi_pkg::RADIUS_W,
    parameter int SIDE_W = 28
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rsi_pkg::ctl_t         ctl_in,
    input  logic [2*ROOT_W-1:0]   rad_in,
    input  logic [SIDE_W-1:0]     side_in,
    output rsi_pkg::ctl_t         ctl_out,
    output logic [ROOT_W-1:0]     root_out,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    rsi_pkg::ctl_t      ctl_reg  [ROOT_W];
    logic [RAD_W-1:0]   x_reg    [ROOT_W];
    logic [REM_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    logic [SIDE_W-1:0]  side_reg [ROOT_W];

    rsi_pkg::ctl_t      ctl_prev  [ROOT_W];
    logic [RAD_W-1:0]   x_prev    [ROOT_W];
    logic [REM_W-1:0]   rem_prev  [ROOT_W];
    logic [ROOT_W-1:0]  root_prev [ROOT_W];
    logic [SIDE_W-1:0]  side_prev [ROOT_W];

    rsi_pkg::ctl_t      ctl_next  [ROOT_W];
    logic [RAD_W-1:0]   x_next    [ROOT_W];
    logic [REM_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0]  root_next [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_step
            if (g == 0) begin : g_first
                assign ctl_prev[g]  = ctl_in;
                assign x_prev[g]    = rad_in;
                assign rem_prev[g]  = '0;
                assign root_prev[g] = '0;
                assign side_prev[g] = side_in;
            end
            else begin : g_rest
                assign ctl_prev[g]  = ctl_reg[g-1];
                assign x_prev[g]    = x_reg[g-1];
                assign rem_prev[g]  = rem_reg[g-1];
                assign root_prev[g] = root_reg[g-1];
                assign side_prev[g] = side_reg[g-1];
            end

            always_comb
            begin
                logic [REM_W-1:0] rem_sh;
                logic [REM_W-1:0] trial;
                logic [REM_W:0]   diff;
                rem_sh = {rem_prev[g][REM_W-3:0], x_prev[g][RAD_W-1 -: 2]};
                trial  = {root_prev[g], 2'b01};
                diff   = {1'b0, rem_sh} - {1'b0, trial};
                if (diff[REM_W]) begin
                    rem_next[g]  = rem_sh;
                    root_next[g] = {root_prev[g][ROOT_W-2:0], 1'b0};
                end
                else begin
                    rem_next[g]  = diff[REM_W-1:0];
                    root_next[g] = {root_prev[g][ROOT_W-2:0], 1'b1};
                end
                x_next[g]   = {x_prev[g][RAD_W-3:0], 2'b00};
                ctl_next[g] = ctl_prev[g];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    ctl_reg[g] <= '0;
                end
                else if (en) begin
                    ctl_reg[g] <= ctl_next[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en) begin
                    x_reg[g]    <= x_next[g];
                    rem_reg[g]  <= rem_next[g];
                    root_reg[g] <= root_next[g];
                    side_reg[g] <= side_prev[g];
                end
            end
        end
    endgenerate

    assign ctl_out  = ctl_reg[ROOT_W-1];
    assign root_out = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

FILE: src/ray_sphere_intersect_core.sv
// Pipeline: from input transaction to output valid, the front stages feed the
// floor square root, one stage per result bit, and then the output register.
// Throughput: one ray per cycle; a stall on the output freezes the whole pipe.
// Reset: clears all valid bits, centre to zero and radius to 1.0.
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Fixed-point ray/sphere intersection: tca from dot(centre - origin, dir),
// miss tests, floor square root of r^2 - d^2, and saturated entry/exit t.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_core #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsi_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_WIDTH-1:0]       origin_x,
    input  logic signed [COORD_WIDTH-1:0]       origin_y,
    input  logic signed [COORD_WIDTH-1:0]       origin_z,
    input  logic signed [rsi_pkg::DIR_W-1:0]    dir_x,
    input  logic signed [rsi_pkg::DIR_W-1:0]    dir_y,
    input  logic signed [rsi_pkg::DIR_W-1:0]    dir_z,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic signed [rsi_pkg::T_W-1:0]      t_near,
    output logic signed [rsi_pkg::T_W-1:0]      t_far
);

    localparam int DIR_W  = rsi_pkg::DIR_W;
    localparam int RAD_W  = rsi_pkg::RADIUS_W;
    localparam int T_W    = rsi_pkg::T_W;
    localparam int LW     = COORD_WIDTH + 1;
    localparam int PD_W   = LW + DIR_W;
    localparam int DOT_W  = PD_W + 2;
    localparam int TCA_W  = DOT_W - 1 - rsi_pkg::DIR_FRAC;
    localparam int SQ_W   = 2 * LW - 1;
    localparam int L2_W   = SQ_W + 2;
    localparam int T2_W   = 2 * TCA_W;
    localparam int R2_W   = 2 * RAD_W;
    localparam int BIG_A  = (L2_W > T2_W) ? L2_W : T2_W;
    localparam int BIG_W  = (BIG_A > R2_W) ? BIG_A : R2_W;
    localparam int DIFF_W = BIG_W + 1;
    localparam int SUM_A  = (TCA_W > RAD_W) ? TCA_W : RAD_W;
    localparam int SUM_W  = ((SUM_A > T_W) ? SUM_A : T_W) + 1;

    localparam logic [SUM_W-1:0] T_MAX = SUM_W'((64'd1 << (T_W - 1)) - 64'd1);

    logic en;

    // configuration
    logic signed [COORD_WIDTH-1:0] center_x_reg;
    logic signed [COORD_WIDTH-1:0] center_y_reg;
    logic signed [COORD_WIDTH-1:0] center_z_reg;
    logic [RAD_W-1:0]              radius_reg;
    logic [R2_W-1:0]               r2_reg;

    // stage 1
    logic                          v1_reg;
    logic signed [LW-1:0]          lx_reg, ly_reg, lz_reg;
    logic signed [DIR_W-1:0]       dx_reg, dy_reg, dz_reg;
    // stage 2
    logic                          v2_reg;
    logic signed [PD_W-1:0]        px_reg, py_reg, pz_reg;
    logic [SQ_W-1:0]               sx_reg, sy_reg, sz_reg;
    logic [SQ_W-1:0]               sx_next, sy_next, sz_next;
    // stage 3
    logic                          v3_reg;
    logic signed [DOT_W-1:0]       dot_reg;
    logic [L2_W-1:0]               l2_3_reg;
    // stage 4
    logic                          v4_reg;
    logic                          neg4_reg;
    logic [TCA_W-1:0]              tca4_reg;
    logic [L2_W-1:0]               l2_4_reg;
    // stage 5
    logic                          v5_reg;
    logic                          neg5_reg;
    logic [TCA_W-1:0]              tca5_reg;
    logic [L2_W-1:0]               l2_5_reg;
    logic [T2_W-1:0]               t2_reg;
    // stage 6
    logic                          v6_reg;
    logic                          neg6_reg;
    logic [TCA_W-1:0]              tca6_reg;
    logic [DIFF_W-1:0]             d_reg;
    // stage 7
    rsi_pkg::ctl_t                 ctl7_reg;
    rsi_pkg::ctl_t                 ctl7_next;
    logic [TCA_W-1:0]              tca7_reg;
    logic [R2_W-1:0]               rad7_reg;
    logic [R2_W-1:0]               rad7_next;
    // square root
    rsi_pkg::ctl_t                 ctl_sq;
    logic [RAD_W-1:0]              thc;
    logic [TCA_W-1:0]              tca_sq;
    // output
    logic                          out_valid_reg;
    logic                          hit_reg, hit_next;
    logic [T_W-1:0]                t_near_reg, t_near_next;
    logic [T_W-1:0]                t_far_reg, t_far_next;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= RAD_W'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready) begin
            case (rsi_pkg::cfg_reg_t'(cfg_index))
                rsi_pkg::REG_CENTER_X: center_x_reg <= cfg_data[COORD_WIDTH-1:0];
                rsi_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[COORD_WIDTH-1:0];
                rsi_pkg::REG_CENTER_Z: center_z_reg <= cfg_data[COORD_WIDTH-1:0];
                rsi_pkg::REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= radius_reg * radius_reg;
    end

    always_comb
    begin
        logic signed [2*LW-1:0] qx, qy, qz;
        qx = lx_reg * lx_reg;
        qy = ly_reg * ly_reg;
        qz = lz_reg * lz_reg;
        sx_next = qx[SQ_W-1:0];
        sy_next = qy[SQ_W-1:0];
        sz_next = qz[SQ_W-1:0];
    end

    always_comb
    begin
        logic [DIFF_W-1:0] d2;
        logic [DIFF_W-1:0] rem;
        d2  = d_reg[DIFF_W-1] ? '0 : d_reg;
        rem = DIFF_W'(r2_reg) - d2;
        ctl7_next.valid = v6_reg;
        ctl7_next.miss  = neg6_reg || rem[DIFF_W-1];
        rad7_next       = ctl7_next.miss ? '0 : rem[R2_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            ctl7_reg <= '0;
        end
        else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            ctl7_reg <= ctl7_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            lx_reg   <= LW'(center_x_reg) - LW'(origin_x);
            ly_reg   <= LW'(center_y_reg) - LW'(origin_y);
            lz_reg   <= LW'(center_z_reg) - LW'(origin_z);
            dx_reg   <= dir_x;
            dy_reg   <= dir_y;
            dz_reg   <= dir_z;

            px_reg   <= lx_reg * dx_reg;
            py_reg   <= ly_reg * dy_reg;
            pz_reg   <= lz_reg * dz_reg;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            sz_reg   <= sz_next;

            dot_reg  <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
            l2_3_reg <= L2_W'(sx_reg) + L2_W'(sy_reg) + L2_W'(sz_reg);

            neg4_reg <= dot_reg[DOT_W-1];
            tca4_reg <= dot_reg[DOT_W-2:rsi_pkg::DIR_FRAC];
            l2_4_reg <= l2_3_reg;

            neg5_reg <= neg4_reg;
            tca5_reg <= tca4_reg;
            l2_5_reg <= l2_4_reg;
            t2_reg   <= tca4_reg * tca4_reg;

            neg6_reg <= neg5_reg;
            tca6_reg <= tca5_reg;
            d_reg    <= DIFF_W'(l2_5_reg) - DIFF_W'(t2_reg);

            tca7_reg <= tca6_reg;
            rad7_reg <= rad7_next;
        end
    end

    rsi_isqrt_pipe #(
        .ROOT_W (RAD_W),
        .SIDE_W (TCA_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl7_reg),
        .rad_in   (rad7_reg),
        .side_in  (tca7_reg),
        .ctl_out  (ctl_sq),
        .root_out (thc),
        .side_out (tca_sq)
    );

    always_comb
    begin
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] dif;
        a   = SUM_W'(tca_sq);
        b   = SUM_W'(thc);
        sum = a + b;
        dif = a - b;
        hit_next = !ctl_sq.miss;
        if (ctl_sq.miss) begin
            t_near_next = '0;
            t_far_next  = '0;
        end
        else begin
            t_far_next = (sum > T_MAX) ? T_MAX[T_W-1:0] : sum[T_W-1:0];
            if (dif[SUM_W-1]) begin
                t_near_next = dif[T_W-1:0];
            end
            else begin
                t_near_next = (dif > T_MAX) ? T_MAX[T_W-1:0] : dif[T_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= ctl_sq.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            hit_reg    <= hit_next;
            t_near_reg <= t_near_next;
            t_far_reg  <= t_far_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_near    = t_near_reg;
    assign t_far     = t_far_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> t_near == '0 && t_far == '0)
        else $error("miss transaction carries nonzero distance");

    a_far_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !t_far[T_W-1])
        else $error("exit distance negative on hit");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> t_far >= t_near)
        else $error("entry distance beyond exit distance");

endmodule
